>>> rtl/bpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier package
// Shared item types, command and event codes, and register indexes.
// ----------------------------------------------------------------------------
package bpc_pkg;

	// Command codes carried by an input item.
	localparam logic [1:0] CMD_PRESS = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_POLL  = 2'd2;

	// Event kinds.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_SHORT = 2'd1;
	localparam logic [1:0] KIND_LONG  = 2'd2;

	// Button code that means no button is tracked.
	localparam logic [1:0] NO_BUTTON = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_SHORT    = 2'd1;
	localparam logic [1:0] REG_LONG     = 2'd2;

	// Configuration port widths and register reset values.
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd70;
	localparam logic [CFG_DATA_W-1:0] SHORT_RESET    = 16'd70;
	localparam logic [CFG_DATA_W-1:0] LONG_RESET     = 16'd1500;

	// One input item.
	typedef struct packed {
		logic [1:0] command;
		logic [1:0] button;
		logic [2:0] button_levels;
	} req_item_t;

	// One result item.
	typedef struct packed {
		logic       event_valid;
		logic [1:0] event_button;
		logic [1:0] event_kind;
	} rsp_item_t;

endpackage

>>> rtl/button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier
// Debounces button press edges and sorts each press into short or long.
// ----------------------------------------------------------------------------
// Items enter an input register, the tracking state is updated from it, and
// a poll writes its event into an output register. The block takes one item
// per clock cycle; a poll result is shown from the output register once the
// poll leaves the input register. Only a stalled result holds up the input
// side, and then only once a poll waits in the input register behind it.
// Press and tick items give no result. The user must write thresholds through
// the configuration port only while no item is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module button_press_classifier
	import bpc_pkg::*;
#(
	parameter int NUM_BUTTONS = 3,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  req_item_t              req_item,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output rsp_item_t              rsp_item,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	logic                   valid_s1;
	req_item_t              item_s1;
	logic                   rsp_valid_q;
	rsp_item_t              rsp_item_q;
	logic                   out_free;
	logic                   is_poll;
	logic                   advance;
	rsp_item_t              result;
	logic [COUNT_WIDTH-1:0] debounce_ticks;
	logic [COUNT_WIDTH-1:0] short_press_ticks;
	logic [COUNT_WIDTH-1:0] long_press_ticks;

	// Flow control: a poll moves on only when the output register is free.
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign is_poll   = (item_s1.command == CMD_POLL);
	assign advance   = valid_s1 && (!is_poll || out_free);
	assign req_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req_item;
		end
	end

	bpc_cfg_regs #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_cfg (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.debounce_ticks   (debounce_ticks),
		.short_press_ticks(short_press_ticks),
		.long_press_ticks (long_press_ticks)
	);

	bpc_core #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (advance),
		.item             (item_s1),
		.debounce_ticks   (debounce_ticks),
		.short_press_ticks(short_press_ticks),
		.long_press_ticks (long_press_ticks),
		.result           (result)
	);

	// Output register holding one poll result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= advance && is_poll;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_poll) begin
			rsp_item_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

`ifndef SYNTH
	// A held item in the input register is neither lost nor altered.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input register item changed while stalled");

	// Every poll that moves on shows up as a result next cycle.
	a_poll_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_poll |=> rsp_valid)
		else $error("poll item produced no result");

	// A reported event carries a real kind and a real button.
	a_event_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_item.event_valid |->
			(rsp_item.event_kind == KIND_SHORT || rsp_item.event_kind == KIND_LONG)
			&& (32'(rsp_item.event_button) < NUM_BUTTONS))
		else $error("reported event has bad kind or button");

	// An empty poll result uses the none codes.
	a_event_none: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.event_valid |->
			rsp_item.event_kind == KIND_NONE && rsp_item.event_button == NO_BUTTON)
		else $error("empty result carries event data");
`endif

endmodule

>>> rtl/bpc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier configuration registers
// Holds the debounce, short press and long press thresholds.
// ----------------------------------------------------------------------------
module bpc_cfg_regs
	import bpc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	output logic [COUNT_WIDTH-1:0] debounce_ticks,
	output logic [COUNT_WIDTH-1:0] short_press_ticks,
	output logic [COUNT_WIDTH-1:0] long_press_ticks
);

	logic [COUNT_WIDTH-1:0] debounce_q;
	logic [COUNT_WIDTH-1:0] short_q;
	logic [COUNT_WIDTH-1:0] long_q;
	logic [COUNT_WIDTH-1:0] wdata;

	// Written values are fitted to the counter width.
	assign wdata = COUNT_WIDTH'(cfg_wdata);

	// Register writes; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= COUNT_WIDTH'(DEBOUNCE_RESET);
			short_q    <= COUNT_WIDTH'(SHORT_RESET);
			long_q     <= COUNT_WIDTH'(LONG_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: begin
					debounce_q <= wdata;
				end
				REG_SHORT: begin
					short_q <= wdata;
				end
				REG_LONG: begin
					long_q <= wdata;
				end
				default: begin
				end
			endcase
		end
	end

	assign debounce_ticks    = debounce_q;
	assign short_press_ticks = short_q;
	assign long_press_ticks  = long_q;

endmodule

>>> rtl/bpc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier core
// Tracking state and its update for press, tick and poll items.
// ----------------------------------------------------------------------------
module bpc_core
	import bpc_pkg::*;
#(
	parameter int NUM_BUTTONS = 3,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  req_item_t              item,
	input  logic [COUNT_WIDTH-1:0] debounce_ticks,
	input  logic [COUNT_WIDTH-1:0] short_press_ticks,
	input  logic [COUNT_WIDTH-1:0] long_press_ticks,
	output rsp_item_t              result
);

	logic [COUNT_WIDTH-1:0] debounce_left_q;
	logic [COUNT_WIDTH-1:0] held_ticks_q;
	logic [1:0]             tracked_q;
	logic [1:0]             kind_q;

	logic [COUNT_WIDTH-1:0] debounce_left_d;
	logic [COUNT_WIDTH-1:0] held_ticks_d;
	logic [1:0]             tracked_d;
	logic [1:0]             kind_d;

	logic       pending;
	logic       debounce_busy;
	logic       button_ok;
	logic       tracked_ok;
	logic [2:0] levels_shifted;
	logic       released;
	logic       past_short;
	logic       past_long;

	// Status terms of the current state.
	assign pending        = (tracked_q != NO_BUTTON) && (kind_q != KIND_NONE);
	assign debounce_busy  = (debounce_left_q != '0);
	assign button_ok      = (32'(item.button) < NUM_BUTTONS);
	assign tracked_ok     = (32'(tracked_q) < NUM_BUTTONS);
	assign levels_shifted = item.button_levels >> tracked_q;
	assign released       = levels_shifted[0];
	assign past_short     = (held_ticks_q >= short_press_ticks);
	assign past_long      = (held_ticks_q >= long_press_ticks);

	// Next state for the item in hand.
	always_comb begin
		debounce_left_d = debounce_left_q;
		held_ticks_d    = held_ticks_q;
		tracked_d       = tracked_q;
		kind_d          = kind_q;
		case (item.command)
			CMD_PRESS: begin
				if (!pending && !debounce_busy && button_ok) begin
					kind_d          = KIND_NONE;
					tracked_d       = item.button;
					debounce_left_d = debounce_ticks;
					held_ticks_d    = '0;
				end
			end
			CMD_TICK: begin
				if (debounce_busy) begin
					debounce_left_d = debounce_left_q - 1'b1;
				end
				if (!pending && tracked_ok) begin
					if (released && !past_short) begin
						tracked_d = NO_BUTTON;
						kind_d    = KIND_NONE;
					end else if (released && !past_long) begin
						kind_d = KIND_SHORT;
					end else if (past_long) begin
						kind_d = KIND_LONG;
					end else begin
						held_ticks_d = held_ticks_q + 1'b1;
					end
				end
			end
			CMD_POLL: begin
				if (pending) begin
					tracked_d = NO_BUTTON;
					kind_d    = KIND_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	// Result of a poll, taken from the state before the update.
	always_comb begin
		if (pending) begin
			result.event_valid  = 1'b1;
			result.event_button = tracked_q;
			result.event_kind   = kind_q;
		end else begin
			result.event_valid  = 1'b0;
			result.event_button = NO_BUTTON;
			result.event_kind   = KIND_NONE;
		end
	end

	// State registers, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_left_q <= '0;
			held_ticks_q    <= '0;
			tracked_q       <= NO_BUTTON;
			kind_q          <= KIND_NONE;
		end else if (fire) begin
			debounce_left_q <= debounce_left_d;
			held_ticks_q    <= held_ticks_d;
			tracked_q       <= tracked_d;
			kind_q          <= kind_d;
		end
	end

endmodule

>>> tb/sv/tb_button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button press classifier testbench
// Drives press, tick and poll items through the valid/ready input and checks
// every polled event against an in-bench model of the debounce counter, the
// held-duration counter and the latched event. Thresholds are rewritten
// between phases while the block is idle. A short directed part covers field
// extremes and corner cases, then random phases send well-formed press
// sequences mixed with noise under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_button_press_classifier;
	import bpc_pkg::*;

	localparam int NUM_BUTTONS = 3;
	localparam int COUNT_WIDTH = 16;

	// Codes that the package leaves unnamed.
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	localparam int SETTLE_CYCLES   = 4;
	localparam int LONG_STALL      = 400;
	localparam int WATCHDOG_CYCLES = 4000;
	localparam int MAX_REPORTS     = 10;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_ITEMS     = 190;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	req_item_t req_item;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp_item;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Thresholds and tracking state as the block should hold them.
	logic [15:0] thr_debounce = DEBOUNCE_RESET;
	logic [15:0] thr_short    = SHORT_RESET;
	logic [15:0] thr_long     = LONG_RESET;
	logic [15:0] pred_debounce_left = '0;
	logic [15:0] pred_held          = '0;
	logic [1:0]  pred_button        = NO_BUTTON;
	logic [1:0]  pred_kind          = KIND_NONE;

	rsp_item_t expected_events[$];

	int  mismatches   = 0;
	int  items_sent   = 0;
	int  polls_seen   = 0;
	int  shorts_seen  = 0;
	int  longs_seen   = 0;
	int  settings     = 0;
	int  quiet_cycles = 0;
	bit  send_gaps    = 1'b0;
	bit  sink_gaps    = 1'b0;
	bit  long_stall_req = 1'b0;

	button_press_classifier #(
		.NUM_BUTTONS(NUM_BUTTONS),
		.COUNT_WIDTH(COUNT_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Model of the classifier
	// ------------------------------------------------------------------

	function automatic bit event_pending();
		return pred_button != NO_BUTTON && pred_kind != KIND_NONE;
	endfunction

	// Applies one accepted item and queues the event a poll must return.
	function automatic void classify_item(req_item_t it);
		logic      released;
		logic      past_short;
		logic      past_long;
		rsp_item_t ev;
		case (it.command)
			CMD_PRESS: begin
				if (!event_pending() && pred_debounce_left == '0 &&
				    int'(it.button) < NUM_BUTTONS) begin
					pred_kind          = KIND_NONE;
					pred_button        = it.button;
					pred_debounce_left = thr_debounce;
					pred_held          = '0;
				end
			end
			CMD_TICK: begin
				if (pred_debounce_left != '0)
					pred_debounce_left = pred_debounce_left - 16'd1;
				if (!event_pending() && int'(pred_button) < NUM_BUTTONS) begin
					released   = it.button_levels[pred_button];
					past_short = pred_held >= thr_short;
					past_long  = pred_held >= thr_long;
					if (released && !past_short) begin
						pred_button = NO_BUTTON;
						pred_kind   = KIND_NONE;
					end else if (released && !past_long) begin
						pred_kind = KIND_SHORT;
					end else if (past_long) begin
						pred_kind = KIND_LONG;
					end else begin
						pred_held = pred_held + 16'd1;
					end
				end
			end
			CMD_POLL: begin
				if (event_pending()) begin
					ev.event_valid  = 1'b1;
					ev.event_button = pred_button;
					ev.event_kind   = pred_kind;
					pred_button     = NO_BUTTON;
					pred_kind       = KIND_NONE;
				end else begin
					ev.event_valid  = 1'b0;
					ev.event_button = NO_BUTTON;
					ev.event_kind   = KIND_NONE;
				end
				expected_events.push_back(ev);
			end
			default: begin
				// The unused command code is dropped.
			end
		endcase
	endfunction

	function automatic void report_mismatch(string what, rsp_item_t want, rsp_item_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("Mismatch (%s): expected valid=%0d button=%0d kind=%0d, ",
				what, want.event_valid, want.event_button, want.event_kind,
				"got valid=%0d button=%0d kind=%0d",
				got.event_valid, got.event_button, got.event_kind);
	endfunction

	function automatic void check_event(rsp_item_t got);
		rsp_item_t want;
		if (expected_events.size() == 0) begin
			report_mismatch("no event expected", '0, got);
		end else begin
			want = expected_events.pop_front();
			polls_seen++;
			if (got.event_valid !== want.event_valid ||
			    got.event_button !== want.event_button ||
			    got.event_kind !== want.event_kind) begin
				report_mismatch("wrong field", want, got);
			end else if (want.event_kind == KIND_SHORT) begin
				shorts_seen++;
			end else if (want.event_kind == KIND_LONG) begin
				longs_seen++;
			end
		end
	endfunction

	// Results are checked before the item accepted on the same edge is modeled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready)
				check_event(rsp_item);
			if (cfg_we) begin
				case (cfg_index)
					REG_DEBOUNCE: thr_debounce = cfg_wdata;
					REG_SHORT:    thr_short    = cfg_wdata;
					REG_LONG:     thr_long     = cfg_wdata;
					default:      ;
				endcase
			end
			if (req_valid && req_ready)
				classify_item(req_item);
		end
	end

	// Ends the run when neither side has moved an item for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("Timeout: no item moved for %0d cycles.", quiet_cycles);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly zero, sometimes a few cycles, rarely a long stretch.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result side: random stalls, or one long hold-off when a test asks.
	initial begin : rsp_sink
		int n;
		rsp_ready = 1'b0;
		@(posedge clk);
		forever begin
			if (long_stall_req) begin
				long_stall_req <= 1'b0;
				rsp_ready <= 1'b0;
				for (n = 0; n < LONG_STALL; n++)
					@(posedge clk);
			end else begin
				n = sink_gaps ? idle_len() : 0;
				if (n > 0) begin
					rsp_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end else begin
					rsp_ready <= 1'b1;
					@(posedge clk);
				end
			end
		end
	end

	function automatic req_item_t make_item(logic [1:0] cmd, logic [1:0] btn, logic [2:0] lv);
		req_item_t it;
		it.command       = cmd;
		it.button        = btn;
		it.button_levels = lv;
		return it;
	endfunction

	// Offers one item, optionally after a gap, and returns once it is taken.
	task automatic send_item(req_item_t it);
		int gap;
		gap = send_gaps ? idle_len() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_item  <= it;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	task automatic send_press(logic [1:0] btn);
		send_item(make_item(CMD_PRESS, btn, 3'($urandom_range(0, 7))));
	endtask

	task automatic send_tick(logic [2:0] lv);
		send_item(make_item(CMD_TICK, 2'($urandom_range(0, 3)), lv));
	endtask

	task automatic send_poll();
		send_item(make_item(CMD_POLL, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7))));
	endtask

	// Stops offering items, waits for every pending event and lets the
	// pipeline empty of presses and ticks that give no result. The first
	// edge lets the model take in the item accepted just before.
	task automatic drain_and_wait();
		req_valid <= 1'b0;
		@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic set_thresholds(logic [15:0] deb, logic [15:0] sh, logic [15:0] lg);
		drain_and_wait();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_SHORT, sh);
		write_reg(REG_LONG, lg);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// Releases every button so any tracked press ends, runs the debounce
	// count out and clears the latched event.
	task automatic quiesce(int ticks);
		send_poll();
		repeat (ticks) send_tick(3'b111);
		send_poll();
	endtask

	// One press of a random button held for a random number of ticks.
	task automatic press_sequence(int lim);
		int          btn;
		int          hold;
		int          i;
		logic [15:0] wait_ticks;
		logic [2:0]  lv;
		btn = $urandom_range(0, NUM_BUTTONS - 1);
		if (event_pending() && $urandom_range(0, 9) != 0)
			send_poll();
		wait_ticks = pred_debounce_left;
		if (wait_ticks != '0 && $urandom_range(0, 6) != 0)
			repeat (wait_ticks) send_tick(3'($urandom_range(0, 7)));
		send_press(2'(btn));
		hold = $urandom_range(0, lim + 3);
		for (i = 0; i <= hold; i++) begin
			lv      = 3'($urandom_range(0, 7));
			lv[btn] = (i == hold);
			send_tick(lv);
			if ($urandom_range(0, 9) == 0)
				send_poll();
		end
		repeat ($urandom_range(0, 2)) send_tick(3'($urandom_range(0, 7)));
		if ($urandom_range(0, 9) != 0)
			send_poll();
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset thresholds: a press held exactly to the short threshold, with a
	// second press edge inside the debounce window.
	task automatic test_reset_thresholds();
		logic [2:0] lv;
		send_poll();
		send_press(2'd1);
		repeat (10) begin
			lv    = 3'($urandom_range(0, 7));
			lv[1] = 1'b0;
			send_tick(lv);
		end
		send_press(2'd0);
		repeat (60) begin
			lv    = 3'($urandom_range(0, 7));
			lv[1] = 1'b0;
			send_tick(lv);
		end
		send_tick(3'b010);
		send_poll();
	endtask

	// Every command, invalid codes, press blocking and all three outcomes.
	task automatic test_directed_basics();
		set_thresholds(16'd2, 16'd3, 16'd5);
		@(posedge clk);
		write_reg(REG_UNUSED, 16'hFFFF);
		cfg_we <= 1'b0;
		send_poll();
		send_item(make_item(CMD_UNUSED, 2'd3, 3'b111));
		send_tick(3'b000);
		send_press(2'd3);
		send_press(2'd2);
		send_press(2'd0);
		send_tick(3'b011);
		send_tick(3'b000);
		send_tick(3'b011);
		send_tick(3'b100);
		send_press(2'd1);
		send_tick(3'b111);
		send_poll();
		send_poll();
		send_press(2'd0);
		repeat (6) send_tick(3'b110);
		send_poll();
		send_press(2'd1);
		send_tick(3'b010);
		send_poll();
	endtask

	// Short threshold above long, zero and unit long thresholds, and the
	// widest short window.
	task automatic test_threshold_corners();
		quiesce(4);
		set_thresholds(16'd0, 16'd6, 16'd2);
		send_press(2'd0);
		send_tick(3'b000);
		send_tick(3'b001);
		send_press(2'd0);
		repeat (3) send_tick(3'b000);
		send_poll();
		set_thresholds(16'd0, 16'd0, 16'd0);
		send_press(2'd2);
		send_tick(3'b100);
		send_poll();
		set_thresholds(16'd1, 16'd0, 16'd1);
		send_press(2'd1);
		send_tick(3'b010);
		send_poll();
		set_thresholds(16'd0, 16'd0, 16'hFFFF);
		send_press(2'd0);
		send_tick(3'b000);
		send_tick(3'b001);
		send_poll();
	endtask

	// The result side holds off while polls keep coming, so the block backs
	// up into its input; then the sender waits for every event to return.
	task automatic test_output_stall();
		quiesce(4);
		set_thresholds(16'd0, 16'd0, 16'd3);
		send_gaps = 1'b0;
		sink_gaps = 1'b0;
		long_stall_req <= 1'b1;
		send_press(2'd1);
		repeat (4) send_tick(3'b000);
		repeat (30) send_poll();
		drain_and_wait();
		send_gaps = 1'b1;
		sink_gaps = 1'b1;
		repeat (6) send_poll();
	endtask

	// Random thresholds per phase; mostly press sequences, some noise.
	task automatic test_random_phases();
		int          p;
		int          start;
		logic [15:0] deb;
		logic [15:0] sh;
		logic [15:0] lg;
		for (p = 0; p < RANDOM_PHASES; p++) begin
			deb = 16'($urandom_range(0, 8));
			sh  = 16'($urandom_range(0, 12));
			lg  = 16'($urandom_range(1, 20));
			if (p == 3 && sh <= lg)
				sh = lg + 16'($urandom_range(1, 4));
			send_gaps = (p != 0) && ($urandom_range(0, 4) != 0);
			sink_gaps = (p != 0) && ($urandom_range(0, 4) != 0);
			set_thresholds(deb, sh, lg);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 75) begin
					press_sequence(int'(lg));
				end else begin
					repeat ($urandom_range(1, 4))
						send_item(make_item(2'($urandom_range(0, 3)),
							2'($urandom_range(0, 3)), 3'($urandom_range(0, 7))));
				end
			end
		end
	endtask

	// All thresholds at their maximum; the debounce window then outlasts
	// the run, so this comes last.
	task automatic test_max_thresholds();
		quiesce(10);
		set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_press(2'd2);
		send_tick(3'b011);
		send_tick(3'b100);
		send_press(2'd0);
		send_tick(3'b000);
		send_poll();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		req_valid = 1'b0;
		req_item  = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		arst_n    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_thresholds();
		test_directed_basics();
		test_threshold_corners();
		test_output_stall();
		test_random_phases();
		test_max_thresholds();

		drain_and_wait();
		repeat (8) @(posedge clk);

		$display("Sent %0d items over %0d threshold settings; %0d polls returned, ",
			items_sent, settings, polls_seen,
			"%0d short and %0d long presses.", shorts_seen, longs_seen);
		$display("Included a %0d-cycle result stall; %0d mismatches, %0d events missing.",
			LONG_STALL, mismatches, expected_events.size());
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
